// File: design/pfc_pkg.sv
// Shared types, format codes and helper functions for the pixel format converter.
package pfc_pkg;

  typedef enum logic [3:0] {
    FMT_BIT   = 4'd0,
    FMT_U8    = 4'd1,
    FMT_S8    = 4'd2,
    FMT_U16   = 4'd3,
    FMT_S16   = 4'd4,
    FMT_U32   = 4'd5,
    FMT_S32   = 4'd6,
    FMT_FLOAT = 4'd7,
    FMT_RGB8  = 4'd8,
    FMT_RGB32 = 4'd9
  } fmt_e;

  localparam logic [0:0] REG_SRC = 1'b0;
  localparam logic [0:0] REG_DST = 1'b1;

  typedef struct packed {
    logic [31:0] chan_r;
    logic [31:0] chan_g;
    logic [31:0] chan_b;
    logic        last_in;
  } pix_in_t;

  typedef struct packed {
    logic [31:0] out_r;
    logic [31:0] out_g;
    logic [31:0] out_b;
    logic        bad_pair;
    logic        last_out;
  } pix_out_t;

  // Destination range as 34-bit signed values.
  typedef struct packed {
    logic signed [33:0] lo;
    logic signed [33:0] hi;
  } range_t;

  function automatic range_t int_range(input logic [3:0] fmt);
    range_t r;
    case (fmt)
      FMT_U8, FMT_RGB8: begin r.lo = '0; r.hi = 34'sd255; end
      FMT_S8:  begin r.lo = -34'sd128; r.hi = 34'sd127; end
      FMT_U16: begin r.lo = '0; r.hi = 34'sd65535; end
      FMT_S16: begin r.lo = -34'sd32768; r.hi = 34'sd32767; end
      FMT_S32: begin r.lo = -34'sd2147483648; r.hi = 34'sd2147483647; end
      default: begin r.lo = '0; r.hi = 34'sd4294967295; end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat_mask(input logic [3:0] fmt,
                                           input logic signed [33:0] v);
    range_t r;
    logic signed [33:0] t;
    r = int_range(fmt);
    t = v;
    if (t < r.lo) t = r.lo;
    if (t > r.hi) t = r.hi;
    case (fmt)
      FMT_U8, FMT_S8, FMT_RGB8: return {24'd0, t[7:0]};
      FMT_U16, FMT_S16:         return {16'd0, t[15:0]};
      default:                  return t[31:0];
    endcase
  endfunction

  function automatic logic signed [33:0] int_in(input logic [3:0] fmt,
                                                input logic [31:0] raw);
    case (fmt)
      FMT_U8:  return {26'd0, raw[7:0]};
      FMT_S8:  return {{26{raw[7]}}, raw[7:0]};
      FMT_U16: return {18'd0, raw[15:0]};
      FMT_S16: return {{18{raw[15]}}, raw[15:0]};
      FMT_U32: return {2'd0, raw};
      default: return {{2{raw[31]}}, raw};
    endcase
  endfunction

  // Stage 1 to stage 2 control.
  typedef struct packed {
    logic [3:0] src;
    logic [3:0] dst;
    logic       last;
  } ctl_t;

endpackage

// File: design/pixel_format_converter_unit.sv
// Top level of the pixel format converter.
// Throughput: one pixel per cycle; busy is never raised.
// Four register stages: decode, normalize/sum, round/average, select.
// Synchronous reset empties the pipeline and sets both formats to u8.
// The receiver cannot stall; each result shows for one cycle.
module pixel_format_converter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pfc_pkg::pix_in_t   pix_in,
  output logic               done,
  output pfc_pkg::pix_out_t  pix_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  logic [3:0] src_format, dst_format;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_format <= pfc_pkg::FMT_U8;
      dst_format <= pfc_pkg::FMT_U8;
    end else if (cfg_valid) begin
      if (cfg_index == pfc_pkg::REG_SRC) src_format <= cfg_data;
      else dst_format <= cfg_data;
    end
  end

  logic               mid_valid;
  pfc_pkg::ctl_t      mid_ctl;
  logic signed [33:0] mid_int;
  logic [33:0]        mid_sum;
  logic [31:0]        mid_fbits, mid_fman, mid_r, mid_g, mid_b;
  logic               mid_fsign;
  logic [7:0]         mid_fexp;

  pfc_front u_front (
    .clk, .rst,
    .in_valid(start & ~busy),
    .pix(pix_in),
    .src(src_format),
    .dst(dst_format),
    .mid_valid, .mid_ctl, .mid_int, .mid_sum, .mid_fbits, .mid_fsign,
    .mid_fexp, .mid_fman, .mid_r, .mid_g, .mid_b
  );

  pfc_back u_back (
    .clk, .rst,
    .mid_valid, .mid_ctl, .mid_int, .mid_sum, .mid_fbits, .mid_fsign,
    .mid_fexp, .mid_fman, .mid_r, .mid_g, .mid_b,
    .out_valid(done),
    .res(pix_out)
  );

endmodule

// File: design/pfc_front.sv
// Stage 1 and 2: operand decode, RGB sum, int magnitude normalize and float exponent.
module pfc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pfc_pkg::pix_in_t    pix,
  input  logic [3:0]          src,
  input  logic [3:0]          dst,
  output logic                mid_valid,
  output pfc_pkg::ctl_t       mid_ctl,
  output logic signed [33:0]  mid_int,
  output logic [33:0]         mid_sum,
  output logic [31:0]         mid_fbits,
  output logic                mid_fsign,
  output logic [7:0]          mid_fexp,
  output logic [31:0]         mid_fman,
  output logic [31:0]         mid_r,
  output logic [31:0]         mid_g,
  output logic [31:0]         mid_b
);

  // stage 1 registers
  logic                v1;
  pfc_pkg::ctl_t       c1;
  logic [31:0]         r1, g1, b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    c1.src  <= src;
    c1.dst  <= dst;
    c1.last <= pix.last_in;
    if (src == pfc_pkg::FMT_RGB8) begin
      r1 <= {24'd0, pix.chan_r[7:0]};
      g1 <= {24'd0, pix.chan_g[7:0]};
      b1 <= {24'd0, pix.chan_b[7:0]};
    end else begin
      r1 <= pix.chan_r;
      g1 <= pix.chan_g;
      b1 <= pix.chan_b;
    end
  end

  // stage 2: int value, sum, integer-to-float magnitude
  logic signed [33:0] iv;
  logic [31:0]        mag;
  logic               neg;
  logic [5:0]         lz;
  logic [31:0]        norm;

  always_comb begin
    iv  = pfc_pkg::int_in(c1.src, r1);
    neg = iv[33];
    mag = neg ? 32'(-iv) : iv[31:0];
    lz  = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lz = 6'(31 - i);
    end
    norm = mag << lz[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= v1;
    end
    mid_ctl   <= c1;
    mid_int   <= iv;
    mid_sum   <= {2'd0, r1} + {2'd0, g1} + {2'd0, b1};
    mid_fbits <= r1;
    mid_fsign <= neg;
    mid_fexp  <= (mag == 32'd0) ? 8'd0 : 8'(8'd158 - {2'd0, lz});
    mid_fman  <= norm;
    mid_r     <= r1;
    mid_g     <= g1;
    mid_b     <= b1;
  end

endmodule

// File: design/pfc_back.sv
// Stages 3 and 4: float rounding, average, saturation and result select.
module pfc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                mid_valid,
  input  pfc_pkg::ctl_t       mid_ctl,
  input  logic signed [33:0]  mid_int,
  input  logic [33:0]         mid_sum,
  input  logic [31:0]         mid_fbits,
  input  logic                mid_fsign,
  input  logic [7:0]          mid_fexp,
  input  logic [31:0]         mid_fman,
  input  logic [31:0]         mid_r,
  input  logic [31:0]         mid_g,
  input  logic [31:0]         mid_b,
  output logic                out_valid,
  output pfc_pkg::pix_out_t   res
);

  // stage 3: round int-to-float, float-to-int, mean
  logic [31:0]        i2f;
  logic [24:0]        rm;
  logic               guard, sticky;
  logic [7:0]         fe;
  logic signed [33:0] f2i;
  logic [7:0]         ex;
  logic [23:0]        sig;
  logic [56:0]        sh;
  logic [33:0]        tq;
  logic [33:0]        avg;
  logic [16:0]        sum_hi, sum_lo;
  logic [18:0]        rem_sum;
  logic [37:0]        qp;
  pfc_pkg::range_t    rg;

  always_comb begin
    guard  = mid_fman[7];
    sticky = |mid_fman[6:0];
    rm = {1'b0, mid_fman[31:8]};
    if (guard && (sticky || mid_fman[8])) rm = rm + 25'd1;
    fe = mid_fexp;
    if (rm[24]) begin
      fe = fe + 8'd1;
      rm = rm >> 1;
    end
    i2f = (mid_fexp == 8'd0) ? 32'd0 : {mid_fsign, fe, rm[22:0]};

    // float to int: x + 0.5 rounded to single, then truncated
    ex  = mid_fbits[30:23];
    sig = (ex == 8'd0) ? {1'b0, mid_fbits[22:0]} : {1'b1, mid_fbits[22:0]};
    rg  = pfc_pkg::int_range(mid_ctl.dst);
    f2i = '0;
    tq  = '0;
    sh  = '0;
    if (ex == 8'hff && mid_fbits[22:0] != 23'd0) begin
      f2i = '0;
    end else if (ex >= 8'd160) begin
      f2i = mid_fbits[31] ? rg.lo : rg.hi;
    end else if (ex < 8'd126) begin
      // just below one half: the sum rounds up to 1.0
      f2i = (!mid_fbits[31] && ex == 8'd125 && (&mid_fbits[22:0])) ? 34'sd1 : 34'sd0;
    end else begin
      // sh = |x| * 2^24
      sh = {33'd0, sig} << (ex - 8'd126);
      if (!mid_fbits[31]) begin
        tq = 34'((sh + 57'h800000) >> 24);
        // odd integer in [2^23, 2^24): tie rounds up to even
        if (ex == 8'd150 && sig[0]) tq = tq + 34'd1;
        f2i = $signed(tq);
      end else begin
        if (sh > 57'h800000) tq = 34'((sh - 57'h800000) >> 24);
        // half an ulp or less is lost in the sum
        if (ex > 8'd150 || (ex == 8'd150 && !sig[0] && mid_fbits[22:0] != 23'd0))
          tq = 34'(sh >> 24);
        f2i = -$signed(tq);
        // below the low end of the destination
        if (sh > (57'(-rg.lo) << 24)) f2i = rg.lo;
      end
    end

    // exact floor(sum/3): sum = hi*2^17 + lo, 2^17 = 3*43690 + 2
    sum_hi  = mid_sum[33:17];
    sum_lo  = mid_sum[16:0];
    rem_sum = {1'b0, sum_hi, 1'b0} + {2'd0, sum_lo};
    qp      = 38'(rem_sum) * 38'd349526;
    avg     = 34'({16'd0, sum_hi} * 33'd43690) + {16'd0, qp[37:20]};
  end

  logic               v3;
  pfc_pkg::ctl_t      c3;
  logic [31:0]        i2f3, fb3, r3, g3, b3;
  logic signed [33:0] f2i3, int3;
  logic [33:0]        avg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= mid_valid;
    end
    c3   <= mid_ctl;
    i2f3 <= i2f;
    f2i3 <= f2i;
    int3 <= mid_int;
    avg3 <= avg;
    fb3  <= mid_fbits;
    r3   <= mid_r;
    g3   <= mid_g;
    b3   <= mid_b;
  end

  // stage 4: select and saturate
  pfc_pkg::pix_out_t nxt;
  logic [3:0]        s, d;
  logic [31:0]       sv;

  always_comb begin
    s = c3.src;
    d = c3.dst;
    nxt = '0;
    nxt.last_out = c3.last;
    sv = '0;
    if (s == pfc_pkg::FMT_BIT) begin
      if (d == pfc_pkg::FMT_BIT) nxt.out_r = {31'd0, r3[0]};
      else if (d == pfc_pkg::FMT_U8) nxt.out_r = r3[0] ? 32'd255 : 32'd0;
      else if (d == pfc_pkg::FMT_RGB8) begin
        nxt.out_r = r3[0] ? 32'd255 : 32'd0;
        nxt.out_g = nxt.out_r;
        nxt.out_b = nxt.out_r;
      end else nxt.bad_pair = 1'b1;
    end else if (s <= pfc_pkg::FMT_FLOAT) begin
      if (d == pfc_pkg::FMT_BIT || d > pfc_pkg::FMT_RGB32) nxt.bad_pair = 1'b1;
      else if (d == pfc_pkg::FMT_FLOAT) begin
        nxt.out_r = (s == pfc_pkg::FMT_FLOAT) ? fb3 : i2f3;
      end else begin
        sv = pfc_pkg::sat_mask(d, (s == pfc_pkg::FMT_FLOAT) ? f2i3 : int3);
        nxt.out_r = sv;
        if (d >= pfc_pkg::FMT_RGB8) begin
          nxt.out_g = sv;
          nxt.out_b = sv;
        end
      end
    end else if (s <= pfc_pkg::FMT_RGB32) begin
      if (d == pfc_pkg::FMT_U8 || d == pfc_pkg::FMT_U32) begin
        nxt.out_r = pfc_pkg::sat_mask(d, $signed(avg3));
      end else if (d == pfc_pkg::FMT_RGB8 || d == pfc_pkg::FMT_RGB32) begin
        nxt.out_r = pfc_pkg::sat_mask(d, $signed({2'd0, r3}));
        nxt.out_g = pfc_pkg::sat_mask(d, $signed({2'd0, g3}));
        nxt.out_b = pfc_pkg::sat_mask(d, $signed({2'd0, b3}));
      end else nxt.bad_pair = 1'b1;
    end else begin
      nxt.bad_pair = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3;
    end
    res <= nxt;
  end

endmodule

// File: design/pfc_checker.sv
// Port-level checker for the pixel format converter, bound to the top level.
module pfc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input pfc_pkg::pix_out_t pix_out,
  input pfc_pkg::pix_in_t  pix_in
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done) else $error("missing done");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4)) else $error("spurious done");

  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> pix_out.last_out == $past(pix_in.last_in, 4)) else $error("last mismatch");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && pix_out.bad_pair |-> pix_out.out_r == 32'd0 && pix_out.out_g == 32'd0
      && pix_out.out_b == 32'd0) else $error("bad pair not zero");

endmodule

bind pixel_format_converter_unit pfc_checker u_chk (
  .clk, .rst, .start, .busy, .done, .pix_out, .pix_in
);

// File: test/tb_pixel_format_converter_unit.sv
// Self-checking testbench for the pixel format converter: directed and random pixels per format pair.
`timescale 1ns / 1ps
module tb_pixel_format_converter_unit;

  localparam logic [3:0] FMT_NONE_LO = 4'd10;
  localparam logic [3:0] FMT_NONE_HI = 4'd15;
  localparam int IdleLimit = 1000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  pfc_pkg::pix_in_t  pix_in = '0;
  logic     done;
  pfc_pkg::pix_out_t pix_out;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [0:0] cfg_index = pfc_pkg::REG_SRC;
  logic [3:0] cfg_data = '0;

  pixel_format_converter_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pix_in(pix_in),
    .done(done), .pix_out(pix_out), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int msb_pos(input logic [135:0] mag);
    int p;
    p = -1;
    for (int i = 0; i < 136; i++) if (mag[i]) p = i;
    return p;
  endfunction

  // Round a magnitude to 24 significant bits, nearest even.
  function automatic logic [135:0] round_sig24(input logic [135:0] mag);
    int p;
    int sh;
    logic [135:0] m, rem, half;
    p = msb_pos(mag);
    if (p <= 23) return mag;
    sh = p - 23;
    m = mag >> sh;
    rem = mag & ((136'd1 << sh) - 136'd1);
    half = 136'd1 << (sh - 1);
    if (rem > half || (rem == half && m[0])) m = m + 136'd1;
    return m << sh;
  endfunction

  function automatic void fmt_limits(input logic [3:0] fmt,
                                     output logic signed [33:0] lo,
                                     output logic signed [33:0] hi);
    case (fmt)
      pfc_pkg::FMT_U8, pfc_pkg::FMT_RGB8: begin lo = 0; hi = 255; end
      pfc_pkg::FMT_S8: begin lo = -128; hi = 127; end
      pfc_pkg::FMT_U16: begin lo = 0; hi = 65535; end
      pfc_pkg::FMT_S16: begin lo = -32768; hi = 32767; end
      pfc_pkg::FMT_S32: begin lo = -34'sd2147483648; hi = 34'sd2147483647; end
      default: begin lo = 0; hi = 34'sd4294967295; end
    endcase
  endfunction

  function automatic logic [31:0] clamp_to(input logic [3:0] fmt,
                                          input logic signed [33:0] v);
    logic signed [33:0] lo, hi, t;
    fmt_limits(fmt, lo, hi);
    t = v;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    case (fmt)
      pfc_pkg::FMT_U8, pfc_pkg::FMT_S8, pfc_pkg::FMT_RGB8: return {24'd0, t[7:0]};
      pfc_pkg::FMT_U16, pfc_pkg::FMT_S16: return {16'd0, t[15:0]};
      default: return t[31:0];
    endcase
  endfunction

  function automatic logic signed [33:0] scalar_value(input logic [3:0] fmt,
                                                      input logic [31:0] raw);
    case (fmt)
      pfc_pkg::FMT_U8: return {26'd0, raw[7:0]};
      pfc_pkg::FMT_S8: return {{26{raw[7]}}, raw[7:0]};
      pfc_pkg::FMT_U16: return {18'd0, raw[15:0]};
      pfc_pkg::FMT_S16: return {{18{raw[15]}}, raw[15:0]};
      pfc_pkg::FMT_U32: return {2'd0, raw};
      default: return {{2{raw[31]}}, raw};
    endcase
  endfunction

  function automatic logic [31:0] int_to_single(input logic signed [33:0] v);
    logic neg;
    logic [135:0] mag, r, mant;
    int p;
    neg = v < 0;
    mag = neg ? 136'(-v) : 136'(v);
    if (mag == 0) return 32'd0;
    r = round_sig24(mag);
    p = msb_pos(r);
    mant = (p >= 23) ? (r >> (p - 23)) : (r << (23 - p));
    return {neg, 8'(127 + p), mant[22:0]};
  endfunction

  // Values carried as fixed point with 64 fraction bits.
  function automatic logic signed [33:0] single_to_int(input logic [31:0] bits,
                                                       input logic [3:0] fmt);
    logic signed [33:0] lo, hi, tv;
    logic signed [135:0] xv, yv, lo_s, hi_s, t;
    logic [135:0] ymag;
    logic [7:0] e;
    logic neg, yneg;
    fmt_limits(fmt, lo, hi);
    e = bits[30:23];
    neg = bits[31];
    if (e == 8'hff && bits[22:0] != 0) return 34'sd0;
    if (e >= 8'd183) return neg ? lo : hi;
    if (e < 8'd86) xv = 0;
    else xv = $signed(136'({1'b1, bits[22:0]}) << (e - 86));
    if (neg) xv = -xv;
    lo_s = lo;
    lo_s = lo_s <<< 64;
    hi_s = hi;
    hi_s = (hi_s <<< 64) + (136'sd1 <<< 63);
    if (xv < lo_s) return lo;
    if (xv >= hi_s) return hi;
    yv = xv + (136'sd1 <<< 63);
    yneg = yv < 0;
    ymag = yneg ? 136'(-yv) : 136'(yv);
    ymag = round_sig24(ymag) >> 64;
    t = $signed(ymag);
    if (yneg) t = -t;
    tv = t[33:0];
    if (tv < lo) tv = lo;
    if (tv > hi) tv = hi;
    return tv;
  endfunction

  class pixel_scoreboard;
    logic [3:0] src, dst;
    pfc_pkg::pix_out_t pending[$];
    int errors, checked;

    function new();
      src = pfc_pkg::FMT_U8;
      dst = pfc_pkg::FMT_U8;
      errors = 0;
      checked = 0;
    endfunction

    function pfc_pkg::pix_out_t convert(pfc_pkg::pix_in_t p);
      pfc_pkg::pix_out_t o;
      logic [31:0] mask, cr, cg, cb;
      logic [33:0] sum;
      logic signed [33:0] v;
      o = '0;
      o.last_out = p.last_in;
      if (src == pfc_pkg::FMT_BIT) begin
        if (dst == pfc_pkg::FMT_BIT) o.out_r = {31'd0, p.chan_r[0]};
        else if (dst == pfc_pkg::FMT_U8) o.out_r = p.chan_r[0] ? 32'hff : 32'h0;
        else if (dst == pfc_pkg::FMT_RGB8) begin
          o.out_r = p.chan_r[0] ? 32'hff : 32'h0;
          o.out_g = o.out_r;
          o.out_b = o.out_r;
        end else o.bad_pair = 1'b1;
      end else if (src <= pfc_pkg::FMT_FLOAT) begin
        if (dst == pfc_pkg::FMT_BIT || dst > pfc_pkg::FMT_RGB32) o.bad_pair = 1'b1;
        else if (src == pfc_pkg::FMT_FLOAT && dst == pfc_pkg::FMT_FLOAT) o.out_r = p.chan_r;
        else if (dst == pfc_pkg::FMT_FLOAT)
          o.out_r = int_to_single(scalar_value(src, p.chan_r));
        else begin
          v = (src == pfc_pkg::FMT_FLOAT) ? single_to_int(p.chan_r, dst) :
                                            scalar_value(src, p.chan_r);
          o.out_r = clamp_to(dst, v);
          if (dst == pfc_pkg::FMT_RGB8 || dst == pfc_pkg::FMT_RGB32) begin
            o.out_g = o.out_r;
            o.out_b = o.out_r;
          end
        end
      end else if (src == pfc_pkg::FMT_RGB8 || src == pfc_pkg::FMT_RGB32) begin
        mask = (src == pfc_pkg::FMT_RGB8) ? 32'hff : 32'hffffffff;
        cr = p.chan_r & mask;
        cg = p.chan_g & mask;
        cb = p.chan_b & mask;
        if (dst == pfc_pkg::FMT_U8 || dst == pfc_pkg::FMT_U32) begin
          sum = 34'(cr) + 34'(cg) + 34'(cb);
          o.out_r = clamp_to(dst, $signed(sum / 34'd3));
        end else if (dst == pfc_pkg::FMT_RGB8 || dst == pfc_pkg::FMT_RGB32) begin
          o.out_r = clamp_to(dst, $signed({2'd0, cr}));
          o.out_g = clamp_to(dst, $signed({2'd0, cg}));
          o.out_b = clamp_to(dst, $signed({2'd0, cb}));
        end else o.bad_pair = 1'b1;
      end else o.bad_pair = 1'b1;
      return o;
    endfunction

    function void note_pixel(pfc_pkg::pix_in_t p);
      pending.push_back(convert(p));
    endfunction

    function void report(string field, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s src=%0d dst=%0d expected %h actual %h", $time, field, src, dst, e, a);
      end
    endfunction

    function void check_pixel(pfc_pkg::pix_out_t got);
      pfc_pkg::pix_out_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none actual %h", $time, got);
        return;
      end
      e = pending.pop_front();
      checked++;
      report("out_r", e.out_r, got.out_r);
      report("out_g", e.out_g, got.out_g);
      report("out_b", e.out_b, got.out_b);
      report("bad_pair", e.bad_pair, got.bad_pair);
      report("last_out", e.last_out, got.last_out);
    endfunction
  endclass

  pixel_scoreboard sb = new();
  int idle_cycles = 0;
  int phases = 0;
  bit burst = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_pixel(pix_out);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_pixel_format_converter_unit: errors");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pfc_pkg::REG_SRC) sb.src = val;
    else sb.dst = val;
  endtask

  task automatic set_pair(input logic [3:0] s, input logic [3:0] d);
    if (s == sb.src && d == sb.dst && phases != 0) return;
    start <= 1'b0;
    wait_drained();
    write_reg(pfc_pkg::REG_SRC, s);
    write_reg(pfc_pkg::REG_DST, d);
    cfg_valid <= 1'b0;
    phases++;
  endtask

  task automatic send_pixel(input pfc_pkg::pix_in_t p);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pix_in <= p;
    do @(posedge clk); while (busy);
    sb.note_pixel(p);
  endtask

  task automatic directed(input logic [3:0] s, input logic [3:0] d, input logic [31:0] r,
                          input logic [31:0] g, input logic [31:0] b, input logic last);
    set_pair(s, d);
    send_pixel('{chan_r: r, chan_g: g, chan_b: b, last_in: last});
  endtask

  function automatic logic [31:0] pick_value(input logic [3:0] s);
    logic [31:0] edges[15] = '{32'h0, 32'h1, 32'h7f, 32'h80, 32'hff, 32'h100, 32'h7fff,
                               32'h8000, 32'hffff, 32'h10000, 32'h7fffffff, 32'h80000000,
                               32'hffffffff, 32'hffffff80, 32'hffff8000};
    int mode;
    logic signed [33:0] v;
    mode = $urandom_range(0, 3);
    if (s == pfc_pkg::FMT_FLOAT && mode == 3) begin
      if ($urandom_range(0, 1)) begin
        v = $signed({2'd0, $urandom()}) >>> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
        return int_to_single(v);
      end
      return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 165)), 23'($urandom())};
    end
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 300) ^ ($urandom_range(0, 1) ? 32'hffffffff : 32'h0);
      default: return edges[$urandom_range(0, 14)];
    endcase
  endfunction

  initial begin
    pfc_pkg::pix_in_t p;
    logic [3:0] s, d;
    int n, total;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_S8, 32'h7fc00000, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_S8, 32'h7f800000, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_S8, 32'hff800000, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_S8, 32'hbf99999a, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_S8, 32'h3effffff, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_S8, 32'h42ff0000, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_S8, 32'hc3008000, 32'h0, 32'h0, 1'b1);
    directed(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_U32, 32'h4f800000, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_U32, 32'h4f7fffff, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_FLOAT, pfc_pkg::FMT_FLOAT, 32'h7fc00001, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_U32, pfc_pkg::FMT_FLOAT, 32'hffffffff, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_U32, pfc_pkg::FMT_FLOAT, 32'h01000001, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_S32, pfc_pkg::FMT_FLOAT, 32'h80000000, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_BIT, pfc_pkg::FMT_RGB8, 32'hffffffff, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_BIT, pfc_pkg::FMT_U8, 32'hfffffffe, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_BIT, pfc_pkg::FMT_BIT, 32'h1, 32'h0, 32'h0, 1'b1);
    directed(pfc_pkg::FMT_RGB32, pfc_pkg::FMT_U8, 32'hffffffff, 32'hffffffff, 32'hffffffff,
             1'b0);
    directed(pfc_pkg::FMT_RGB32, pfc_pkg::FMT_U32, 32'hffffffff, 32'hffffffff, 32'hfffffffe,
             1'b0);
    directed(pfc_pkg::FMT_RGB8, pfc_pkg::FMT_U32, 32'hffffff01, 32'h102, 32'h2ff, 1'b0);
    directed(pfc_pkg::FMT_RGB8, pfc_pkg::FMT_S8, 32'h12, 32'h34, 32'h56, 1'b0);
    directed(pfc_pkg::FMT_S16, pfc_pkg::FMT_U8, 32'h8000, 32'h0, 32'h0, 1'b0);
    directed(pfc_pkg::FMT_U8, pfc_pkg::FMT_BIT, 32'hff, 32'h0, 32'h0, 1'b0);
    directed(FMT_NONE_HI, pfc_pkg::FMT_U16, 32'h1234, 32'h0, 32'h0, 1'b1);
    directed(pfc_pkg::FMT_U8, FMT_NONE_LO, 32'h12, 32'h0, 32'h0, 1'b0);

    total = 0;
    while (total < 1250) begin
      s = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      d = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      set_pair(s, d);
      burst = ($urandom_range(0, 2) == 0);
      n = $urandom_range(3, 14);
      for (int i = 0; i < n; i++) begin
        p.chan_r = pick_value(s);
        p.chan_g = pick_value(s);
        p.chan_b = pick_value(s);
        p.last_in = ($urandom_range(0, 7) == 0);
        send_pixel(p);
      end
      total += n;
    end
    start <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d format settings with %0d checked pixels, float edges and bad pairs.",
             phases, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_pixel_format_converter_unit: clean");
    end else begin
      $display("tb_pixel_format_converter_unit: errors");
    end
    $finish;
  end

endmodule

// File: pixel_format_converter_unit.f
design/pfc_pkg.sv
design/pfc_front.sv
design/pfc_back.sv
design/pixel_format_converter_unit.sv
design/pfc_checker.sv
test/tb_pixel_format_converter_unit.sv
